// ----- src/assert_macros.svh -----
// assertion macros used by rht_core
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// ----- src/rht_pkg.sv -----
// shared types and constants of the rtsp header tokenizer
// no dependencies
package rht_pkg;

    localparam int MAX_HEADERS   = 32;
    localparam int POSITION_BITS = 16;
    localparam int POS_W         = POSITION_BITS;
    localparam int HCNT_W        = $clog2(MAX_HEADERS + 1);

    localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};
    localparam logic [HCNT_W-1:0] HDR_LIMIT = HCNT_W'(MAX_HEADERS);

    // characters the parser looks at
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // byte roles
    localparam logic [3:0] ROLE_BLANK  = 4'd0;
    localparam logic [3:0] ROLE_FIRST  = 4'd1;
    localparam logic [3:0] ROLE_URI    = 4'd2;
    localparam logic [3:0] ROLE_PROTO  = 4'd3;
    localparam logic [3:0] ROLE_STATUS = 4'd4;
    localparam logic [3:0] ROLE_REASON = 4'd5;
    localparam logic [3:0] ROLE_NAME   = 4'd6;
    localparam logic [3:0] ROLE_VALUE  = 4'd7;
    localparam logic [3:0] ROLE_EOL    = 4'd8;
    localparam logic [3:0] ROLE_EMPTY  = 4'd9;
    localparam logic [3:0] ROLE_BODY   = 4'd10;
    localparam logic [3:0] ROLE_ERR    = 4'd11;

    // message kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_REQ  = 2'd1;
    localparam logic [1:0] KIND_RESP = 2'd2;

    // error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_SHORT     = 4'd1;
    localparam logic [3:0] ERR_NO_DELIM  = 4'd2;
    localparam logic [3:0] ERR_START     = 4'd3;
    localparam logic [3:0] ERR_STATUS    = 4'd4;
    localparam logic [3:0] ERR_NO_EOL    = 4'd5;
    localparam logic [3:0] ERR_CONT      = 4'd6;
    localparam logic [3:0] ERR_NO_COLON  = 4'd7;
    localparam logic [3:0] ERR_TOO_MANY  = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [15:0] byte_offset;
        logic [3:0]  byte_role;
        logic        field_start;
        logic [4:0]  header_index;
        logic [1:0]  message_kind;
        logic [9:0]  status_code;
        logic        header_done;
        logic        parse_error;
        logic [3:0]  error_kind;
        logic [15:0] header_length;
        logic [5:0]  header_total;
    } out_t;

endpackage

// ----- src/rht_in_stage.sv -----
// input register of the tokenizer
// depends on rht_pkg
module rht_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  rht_pkg::in_t  byte_item,
    input  logic          take,
    output logic          held_valid,
    output rht_pkg::in_t  held_item
);
    import rht_pkg::*;

    logic valid_reg;
    logic valid_next;
    in_t  item_reg;

    assign byte_ready = !valid_reg || take;
    assign valid_next = (byte_valid && byte_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg <= byte_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ----- src/rht_core.sv -----
// parser state and per-byte tokenizing logic
// depends on rht_pkg and assert_macros.svh
module rht_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  rht_pkg::in_t  item,
    output rht_pkg::out_t res
);
    import rht_pkg::*;
    `include "assert_macros.svh"

    localparam logic [4:0] PH_FW        = 5'd0;
    localparam logic [4:0] PH_SP_URI    = 5'd1;
    localparam logic [4:0] PH_URI       = 5'd2;
    localparam logic [4:0] PH_SP_PROTO  = 5'd3;
    localparam logic [4:0] PH_PROTO     = 5'd4;
    localparam logic [4:0] PH_SP_STAT   = 5'd5;
    localparam logic [4:0] PH_STAT      = 5'd6;
    localparam logic [4:0] PH_SP_REASON = 5'd7;
    localparam logic [4:0] PH_REASON    = 5'd8;
    localparam logic [4:0] PH_CR        = 5'd9;
    localparam logic [4:0] PH_LINE      = 5'd10;
    localparam logic [4:0] PH_BLANK_CR  = 5'd11;
    localparam logic [4:0] PH_NAME      = 5'd12;
    localparam logic [4:0] PH_NAME_SP   = 5'd13;
    localparam logic [4:0] PH_SP_VALUE  = 5'd14;
    localparam logic [4:0] PH_VALUE     = 5'd15;
    localparam logic [4:0] PH_HCR       = 5'd16;

    logic [4:0]        ph_reg,   ph_next;
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [HCNT_W-1:0] hcnt_reg, hcnt_next;
    logic [9:0]        acc_reg,  acc_next;
    logic [1:0]        dcnt_reg, dcnt_next;
    logic [1:0]        kind_reg, kind_next;
    logic [3:0]        errl_reg, errl_next;
    logic              done_reg, done_next;
    logic [POS_W-1:0]  hlen_reg, hlen_next;

    logic [7:0] c;
    logic       is_cr, is_lf, is_sp, is_tab, is_colon, is_digit;
    logic [3:0] role;
    logic       fs;
    logic [3:0] err;
    logic       done_now;
    logic       pulse;

    assign c        = item.data_byte;
    assign is_cr    = (c == CH_CR);
    assign is_lf    = (c == CH_LF);
    assign is_sp    = (c == CH_SP);
    assign is_tab   = (c == CH_TAB);
    assign is_colon = (c == CH_COLON);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

    always_comb
    begin
        ph_next   = ph_reg;
        hcnt_next = hcnt_reg;
        acc_next  = acc_reg;
        dcnt_next = dcnt_reg;
        kind_next = kind_reg;
        errl_next = errl_reg;
        done_next = done_reg;
        hlen_next = hlen_reg;
        role      = ROLE_BLANK;
        fs        = 1'b0;
        err       = ERR_NONE;
        done_now  = 1'b0;
        pulse     = 1'b0;

        priority if (errl_reg != ERR_NONE)
        begin
            role = ROLE_ERR;
        end
        else if (done_reg)
        begin
            role = ROLE_BODY;
        end
        else
        begin
            unique case (ph_reg)
                PH_FW:
                begin
                    priority if (is_cr || is_lf)
                    begin
                        err = ERR_START;
                    end
                    else if (is_sp)
                    begin
                        kind_next = (kind_reg == KIND_NONE) ? KIND_REQ : kind_reg;
                        ph_next   = (kind_next == KIND_RESP) ? PH_SP_STAT : PH_SP_URI;
                    end
                    else
                    begin
                        if (c == CH_SLASH && kind_reg == KIND_NONE)
                        begin
                            kind_next = KIND_RESP;
                        end
                        role = ROLE_FIRST;
                        fs   = (pos_reg == '0);
                    end
                end
                PH_SP_URI, PH_URI:
                begin
                    priority if (is_cr || is_lf)
                    begin
                        err = ERR_START;
                    end
                    else if (is_sp)
                    begin
                        if (ph_reg == PH_URI)
                        begin
                            ph_next = PH_SP_PROTO;
                        end
                    end
                    else
                    begin
                        role    = ROLE_URI;
                        fs      = (ph_reg == PH_SP_URI);
                        ph_next = PH_URI;
                    end
                end
                PH_SP_PROTO, PH_PROTO, PH_SP_REASON, PH_REASON:
                begin
                    priority if (is_cr)
                    begin
                        role    = ROLE_EOL;
                        ph_next = PH_CR;
                    end
                    else if (is_lf)
                    begin
                        role    = ROLE_EOL;
                        ph_next = PH_LINE;
                    end
                    else if (is_sp && (ph_reg == PH_SP_PROTO || ph_reg == PH_SP_REASON))
                    begin
                        role = ROLE_BLANK;
                    end
                    else if (ph_reg == PH_SP_PROTO || ph_reg == PH_PROTO)
                    begin
                        role    = ROLE_PROTO;
                        fs      = (ph_reg == PH_SP_PROTO);
                        ph_next = PH_PROTO;
                    end
                    else
                    begin
                        role    = ROLE_REASON;
                        fs      = (ph_reg == PH_SP_REASON);
                        ph_next = PH_REASON;
                    end
                end
                PH_SP_STAT:
                begin
                    priority if (is_sp)
                    begin
                        role = ROLE_BLANK;
                    end
                    else if (is_digit)
                    begin
                        role      = ROLE_STATUS;
                        fs        = 1'b1;
                        acc_next  = {6'd0, c[3:0]};
                        dcnt_next = 2'd1;
                        ph_next   = PH_STAT;
                    end
                    else
                    begin
                        err = ERR_STATUS;
                    end
                end
                PH_STAT:
                begin
                    priority if (dcnt_reg != 2'd3)
                    begin
                        if (is_digit)
                        begin
                            role      = ROLE_STATUS;
                            // times ten as two shifts
                            acc_next  = 10'((acc_reg << 3) + (acc_reg << 1) + {6'd0, c[3:0]});
                            dcnt_next = dcnt_reg + 2'd1;
                        end
                        else
                        begin
                            err = ERR_STATUS;
                        end
                    end
                    else if (is_sp)
                    begin
                        ph_next = PH_SP_REASON;
                    end
                    else
                    begin
                        err = ERR_STATUS;
                    end
                end
                PH_CR, PH_HCR:
                begin
                    if (is_lf)
                    begin
                        role = ROLE_EOL;
                        if (ph_reg == PH_HCR)
                        begin
                            hcnt_next = hcnt_reg + 1'b1;
                        end
                        ph_next = PH_LINE;
                    end
                    else
                    begin
                        err = ERR_NO_EOL;
                    end
                end
                PH_LINE:
                begin
                    priority if (is_cr)
                    begin
                        role    = ROLE_EMPTY;
                        ph_next = PH_BLANK_CR;
                    end
                    else if (is_lf)
                    begin
                        role     = ROLE_EMPTY;
                        done_now = 1'b1;
                    end
                    else if (is_sp || is_tab)
                    begin
                        err = ERR_CONT;
                    end
                    else if (hcnt_reg >= HDR_LIMIT)
                    begin
                        err = ERR_TOO_MANY;
                    end
                    else if (is_colon)
                    begin
                        ph_next = PH_SP_VALUE;
                    end
                    else
                    begin
                        role    = ROLE_NAME;
                        fs      = 1'b1;
                        ph_next = PH_NAME;
                    end
                end
                PH_BLANK_CR:
                begin
                    if (is_lf)
                    begin
                        role     = ROLE_EMPTY;
                        done_now = 1'b1;
                    end
                    else
                    begin
                        err = ERR_NO_EOL;
                    end
                end
                PH_NAME:
                begin
                    priority if (is_colon)
                    begin
                        ph_next = PH_SP_VALUE;
                    end
                    else if (is_sp)
                    begin
                        ph_next = PH_NAME_SP;
                    end
                    else if (is_cr || is_lf)
                    begin
                        err = ERR_NO_COLON;
                    end
                    else
                    begin
                        role = ROLE_NAME;
                    end
                end
                PH_NAME_SP:
                begin
                    priority if (is_colon)
                    begin
                        ph_next = PH_SP_VALUE;
                    end
                    else if (!is_sp)
                    begin
                        err = ERR_NO_COLON;
                    end
                    else
                    begin
                        role = ROLE_BLANK;
                    end
                end
                PH_SP_VALUE, PH_VALUE:
                begin
                    priority if (is_cr)
                    begin
                        role    = ROLE_EOL;
                        ph_next = PH_HCR;
                    end
                    else if (is_lf)
                    begin
                        role      = ROLE_EOL;
                        hcnt_next = hcnt_reg + 1'b1;
                        ph_next   = PH_LINE;
                    end
                    else if ((is_sp || is_tab) && ph_reg == PH_SP_VALUE)
                    begin
                        role = ROLE_BLANK;
                    end
                    else
                    begin
                        role    = ROLE_VALUE;
                        fs      = (ph_reg == PH_SP_VALUE);
                        ph_next = PH_VALUE;
                    end
                end
                default:
                begin
                    err = ERR_START;
                end
            endcase

            // end of message checks, by the phase reached
            if (err == ERR_NONE && !done_now && item.is_last)
            begin
                priority if (pos_reg < POS_W'(3))
                begin
                    err = ERR_SHORT;
                end
                else if (ph_next == PH_LINE || ph_next == PH_BLANK_CR)
                begin
                    done_now = 1'b1;
                end
                else if (ph_next == PH_FW)
                begin
                    err = (kind_next == KIND_NONE) ? ERR_NO_DELIM : ERR_START;
                end
                else if (ph_next == PH_SP_URI || ph_next == PH_URI)
                begin
                    err = ERR_START;
                end
                else if (ph_next == PH_SP_STAT || ph_next == PH_STAT)
                begin
                    err = ERR_STATUS;
                end
                else if (ph_next == PH_NAME || ph_next == PH_NAME_SP)
                begin
                    err = ERR_NO_COLON;
                end
                else
                begin
                    err = ERR_NO_EOL;
                end
            end

            priority if (err != ERR_NONE)
            begin
                errl_next = err;
                role      = ROLE_ERR;
                fs        = 1'b0;
            end
            else if (done_now)
            begin
                done_next = 1'b1;
                pulse     = 1'b1;
                hlen_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 1'b1;
            end
            else
            begin
                done_next = done_reg;
            end
        end
    end

    always_comb
    begin
        res.byte_offset   = 16'(pos_reg);
        res.byte_role     = role;
        res.field_start   = fs;
        res.header_index  = 5'(hcnt_reg);
        res.message_kind  = kind_next;
        res.status_code   = acc_next;
        res.header_done   = pulse;
        res.parse_error   = (errl_next != ERR_NONE);
        res.error_kind    = errl_next;
        res.header_length = done_next ? 16'(hlen_next) : 16'd0;
        res.header_total  = 6'(hcnt_next);
    end

    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_FW;
            pos_reg  <= '0;
            hcnt_reg <= '0;
            acc_reg  <= '0;
            dcnt_reg <= '0;
            kind_reg <= KIND_NONE;
            errl_reg <= ERR_NONE;
            done_reg <= 1'b0;
            hlen_reg <= '0;
        end
        else if (step)
        begin
            if (item.is_last)
            begin
                ph_reg   <= PH_FW;
                pos_reg  <= '0;
                hcnt_reg <= '0;
                acc_reg  <= '0;
                dcnt_reg <= '0;
                kind_reg <= KIND_NONE;
                errl_reg <= ERR_NONE;
                done_reg <= 1'b0;
                hlen_reg <= '0;
            end
            else
            begin
                ph_reg   <= ph_next;
                pos_reg  <= pos_next;
                hcnt_reg <= hcnt_next;
                acc_reg  <= acc_next;
                dcnt_reg <= dcnt_next;
                kind_reg <= kind_next;
                errl_reg <= errl_next;
                done_reg <= done_next;
                hlen_reg <= hlen_next;
            end
        end
    end

    // done and error never latch together
    `ASSERT_NEVER(a_done_and_err, done_reg && errl_reg != ERR_NONE, "done with error latched")
    // header counter stays within the limit
    `ASSERT_CLK(a_hdr_bound, hcnt_reg <= HDR_LIMIT, "header counter over limit")
    // a last byte restarts the message state
    `ASSERT_CLK(a_last_restart, step && item.is_last |=> pos_reg == '0 && errl_reg == ERR_NONE
        && !done_reg && hcnt_reg == '0, "state not restarted after last byte")

endmodule

// ----- src/rht_out_stage.sv -----
// result register of the tokenizer
// depends on rht_pkg
module rht_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    output logic          load_ready,
    input  rht_pkg::out_t load_item,
    output logic          tok_valid,
    input  logic          tok_ready,
    output rht_pkg::out_t tok_item
);
    import rht_pkg::*;

    logic valid_reg;
    logic valid_next;
    out_t item_reg;

    assign load_ready = !valid_reg || tok_ready;
    assign valid_next = load || (valid_reg && !tok_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign tok_valid = valid_reg;
    assign tok_item  = item_reg;

endmodule

// ----- src/rtsp_header_tokenizer.sv -----
// rtsp header tokenizer: tags each message byte with its role, one result per byte
// a byte waits in the input register until a step loads its result into the result register
// throughput: one byte per cycle unless tok_ready stalls, set by the single parse step
// reset: rst_n clears both stage valids and the parser state to message start
// depends on rht_pkg, rht_in_stage, rht_core, rht_out_stage
module rtsp_header_tokenizer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_ready,
    input  rht_pkg::in_t  byte_item,
    output logic          tok_valid,
    input  logic          tok_ready,
    output rht_pkg::out_t tok_item
);
    import rht_pkg::*;

    // input register outputs
    logic held_valid;
    in_t  held_item;

    // a parse step fires when a held byte can move into the result register
    logic load_ready;
    logic step;
    out_t step_res;

    assign step = held_valid && load_ready;

    // input register: takes a new transaction when it is empty or when the held byte moves on
    rht_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .take       (step),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // parser state and per-byte decode, updated only on a step
    rht_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (held_item),
        .res   (step_res)
    );

    // result register: holds a finished transaction until it is taken
    rht_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .load_ready (load_ready),
        .load_item  (step_res),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_item   (tok_item)
    );

endmodule
